// ===== design/pagp_pkg.sv =====
// shared types and constants of the pin-addressed gpio port
package pagp_pkg;

  // port geometry
  localparam int BANKS_PER_CHIP        = 16;
  localparam int SECOND_CHIP_FIRST_PIN = 352;
  localparam int SECOND_CHIP_PINS      = 12;

  localparam int PIN_W   = 9;
  localparam int WORD_W  = 32;
  localparam int FLAT_BANKS = 2 * BANKS_PER_CHIP;
  localparam int FLAT_W  = (FLAT_BANKS > 1) ? $clog2(FLAT_BANKS) : 1;

  localparam int FUNC_DEPTH = FLAT_BANKS * 4;
  localparam int PULL_DEPTH = FLAT_BANKS * 2;
  localparam int DATA_DEPTH = FLAT_BANKS;
  localparam int FUNC_AW    = FLAT_W + 2;
  localparam int PULL_AW    = FLAT_W + 1;
  localparam int DATA_AW    = FLAT_W;

  // request codes
  localparam logic [2:0] REQ_SETUP     = 3'd0;
  localparam logic [2:0] REQ_SET_PULL  = 3'd1;
  localparam logic [2:0] REQ_WRITE_LVL = 3'd2;
  localparam logic [2:0] REQ_READ_LVL  = 3'd3;
  localparam logic [2:0] REQ_READ_FUNC = 3'd4;

  // direction codes
  localparam logic [1:0] DIR_INPUT  = 2'd0;
  localparam logic [1:0] DIR_OUTPUT = 2'd1;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [PIN_W-1:0] pin;
    logic [1:0]       direction;
    logic [1:0]       pull;
    logic             level;
  } req_t;

  typedef struct packed {
    logic [2:0] read_value;
    logic       bad_direction;
  } rsp_t;

endpackage

// ===== design/pagp_ram.sv =====
// generic simple dual-port ram with registered read
module pagp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pin_addressed_gpio_port.sv =====
// top level of the pin-addressed gpio port register file
//
// For each request, the addressed function, pull and data words are read
// from their rams at the edge where the request transfers, and in the
// following cycle the word is modified, written back and the result is
// loaded into the output register. One request is in flight at a time: a
// new request is not taken until the last one has been written back, as
// the rams turn from read to write-back. A new request transfers only
// while the output register is empty or its result is being taken.
// Every ram word has a valid flag that reset clears, and an unwritten word
// reads as zero, so no clearing pass is needed after reset.
module pin_addressed_gpio_port (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pagp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pagp_pkg::rsp_t rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic accept;

  // pin location of the incoming request
  logic                          in_chip;
  logic [pagp_pkg::PIN_W-1:0]    in_local;
  logic [3:0]                    in_bank;
  logic                          in_ok;
  logic [pagp_pkg::FLAT_W-1:0]   in_flat;
  logic [4:0]                    in_index;

  // held request
  pagp_pkg::req_t              hreq;
  logic                        h_ok;
  logic [pagp_pkg::FLAT_W-1:0] h_flat;
  logic [4:0]                  h_index;

  // ram ports
  logic [pagp_pkg::FUNC_AW-1:0] f_raddr, f_waddr;
  logic [pagp_pkg::PULL_AW-1:0] p_raddr, p_waddr;
  logic [pagp_pkg::DATA_AW-1:0] d_raddr, d_waddr;
  logic [pagp_pkg::WORD_W-1:0]  f_rdata, p_rdata, d_rdata;
  logic [pagp_pkg::WORD_W-1:0]  f_wdata, p_wdata, d_wdata;
  logic                         f_we, p_we, d_we;

  // word valid flags
  logic [pagp_pkg::FUNC_DEPTH-1:0] f_vld;
  logic [pagp_pkg::PULL_DEPTH-1:0] p_vld;
  logic [pagp_pkg::DATA_DEPTH-1:0] d_vld;
  logic                            f_vq, p_vq, d_vq;

  logic [pagp_pkg::WORD_W-1:0] f_word, p_word, d_word;
  pagp_pkg::rsp_t              rsp_next;

  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  // chip, bank and index of the incoming pin
  always_comb begin
    in_chip  = 1'b0;
    in_local = req.pin;
    if ((int'(req.pin) >= pagp_pkg::SECOND_CHIP_FIRST_PIN) &&
        (int'(req.pin) < pagp_pkg::SECOND_CHIP_FIRST_PIN + pagp_pkg::SECOND_CHIP_PINS)) begin
      in_chip  = 1'b1;
      in_local = req.pin - pagp_pkg::PIN_W'(pagp_pkg::SECOND_CHIP_FIRST_PIN);
    end
    in_bank  = in_local[8:5];
    in_index = in_local[4:0];
    in_ok    = int'(in_bank) < pagp_pkg::BANKS_PER_CHIP;
    in_flat  = pagp_pkg::FLAT_W'((in_chip ? pagp_pkg::BANKS_PER_CHIP : 0) + int'(in_bank));
  end

  assign f_raddr = {in_flat, in_index[4:3]};
  assign p_raddr = {in_flat, in_index[4]};
  assign d_raddr = in_flat;

  assign f_waddr = {h_flat, h_index[4:3]};
  assign p_waddr = {h_flat, h_index[4]};
  assign d_waddr = h_flat;

  pagp_ram #(.WIDTH(pagp_pkg::WORD_W), .DEPTH(pagp_pkg::FUNC_DEPTH)) u_func_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(accept), .raddr(f_raddr), .rdata(f_rdata)
  );

  pagp_ram #(.WIDTH(pagp_pkg::WORD_W), .DEPTH(pagp_pkg::PULL_DEPTH)) u_pull_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(accept), .raddr(p_raddr), .rdata(p_rdata)
  );

  pagp_ram #(.WIDTH(pagp_pkg::WORD_W), .DEPTH(pagp_pkg::DATA_DEPTH)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(accept), .raddr(d_raddr), .rdata(d_rdata)
  );

  // hold the request and its location
  always_ff @(posedge clk) begin
    if (accept) begin
      hreq    <= req;
      h_ok    <= in_ok;
      h_flat  <= in_flat;
      h_index <= in_index;
    end
  end

  // valid flags, captured alongside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= '0;
      p_vld <= '0;
      d_vld <= '0;
      f_vq  <= 1'b0;
      p_vq  <= 1'b0;
      d_vq  <= 1'b0;
    end else begin
      if (f_we) begin
        f_vld[f_waddr] <= 1'b1;
      end
      if (p_we) begin
        p_vld[p_waddr] <= 1'b1;
      end
      if (d_we) begin
        d_vld[d_waddr] <= 1'b1;
      end
      if (accept) begin
        f_vq <= f_vld[f_raddr];
        p_vq <= p_vld[p_raddr];
        d_vq <= d_vld[d_raddr];
      end
    end
  end

  assign f_word = f_vq ? f_rdata : '0;
  assign p_word = p_vq ? p_rdata : '0;
  assign d_word = d_vq ? d_rdata : '0;

  // modify the words and form the result
  always_comb begin
    f_wdata  = f_word;
    p_wdata  = p_word;
    d_wdata  = d_word;
    f_we     = 1'b0;
    p_we     = 1'b0;
    d_we     = 1'b0;
    rsp_next = '0;
    p_wdata[{h_index[3:0], 1'b0} +: 2] = hreq.pull;
    f_wdata[{h_index[2:0], 2'b00} +: 3] = (hreq.direction == pagp_pkg::DIR_OUTPUT) ? 3'd1 : 3'd0;
    d_wdata[h_index] = hreq.level;
    case (hreq.req_type)
      pagp_pkg::REQ_SETUP: begin
        rsp_next.bad_direction = (hreq.direction != pagp_pkg::DIR_INPUT) &&
                                 (hreq.direction != pagp_pkg::DIR_OUTPUT);
        p_we = h_ok;
        f_we = h_ok && !rsp_next.bad_direction;
      end
      pagp_pkg::REQ_SET_PULL: begin
        p_we = h_ok;
      end
      pagp_pkg::REQ_WRITE_LVL: begin
        d_we = h_ok;
      end
      pagp_pkg::REQ_READ_LVL: begin
        rsp_next.read_value = h_ok ? {2'b00, d_word[h_index]} : 3'd0;
      end
      pagp_pkg::REQ_READ_FUNC: begin
        rsp_next.read_value = h_ok ? f_word[{h_index[2:0], 2'b00} +: 3] : 3'd0;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    if (state != ST_BUSY) begin
      f_we = 1'b0;
      p_we = 1'b0;
      d_we = 1'b0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_BUSY;
          end
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        ST_BUSY: begin
          state     <= ST_IDLE;
          rsp_valid <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_BUSY) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== bench/pin_addressed_gpio_port_test.sv =====
// self-checking testbench of the pin-addressed gpio port register file
module pin_addressed_gpio_port_test;

  timeunit 1ns;
  timeprecision 1ps;

  // request and direction codes outside the package's valid set
  localparam logic [2:0] REQ_FIRST_UNKNOWN = 3'd5;
  localparam logic [2:0] REQ_LAST_UNKNOWN  = 3'd7;
  localparam logic [1:0] DIR_FIRST_BAD     = 2'd2;
  localparam logic [1:0] DIR_LAST_BAD      = 2'd3;

  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int HOLD_OFF_LEN   = 250;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_PIN        = (1 << pagp_pkg::PIN_W) - 1;
  localparam int FIRST_PIN      = pagp_pkg::SECOND_CHIP_FIRST_PIN;
  localparam int LAST_PIN       = pagp_pkg::SECOND_CHIP_FIRST_PIN +
                                  pagp_pkg::SECOND_CHIP_PINS - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  pagp_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  pagp_pkg::rsp_t rsp;

  pin_addressed_gpio_port i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // own copy of the port registers
  logic [pagp_pkg::WORD_W-1:0] func_words [pagp_pkg::FUNC_DEPTH];
  logic [pagp_pkg::WORD_W-1:0] pull_words [pagp_pkg::PULL_DEPTH];
  logic [pagp_pkg::WORD_W-1:0] data_words [pagp_pkg::DATA_DEPTH];

  pagp_pkg::req_t queued_requests [$];
  pagp_pkg::rsp_t predicted_rsps [$];
  int   error_count = 0;
  int   accepted_reqs = 0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  always #4 clk = ~clk;

  // gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // apply one request to the register copy and return its result
  function automatic pagp_pkg::rsp_t apply_request(input pagp_pkg::req_t r);
    pagp_pkg::rsp_t o;
    int unsigned    chip, local_pin, bank, idx, flat, fw, fsh, pw, psh;
    bit             in_range;
    o = '0;
    chip = 0;
    local_pin = 32'(r.pin);
    if (local_pin >= pagp_pkg::SECOND_CHIP_FIRST_PIN &&
        local_pin < pagp_pkg::SECOND_CHIP_FIRST_PIN + pagp_pkg::SECOND_CHIP_PINS) begin
      chip = 1;
      local_pin -= pagp_pkg::SECOND_CHIP_FIRST_PIN;
    end
    bank = local_pin / 32;
    idx = local_pin % 32;
    in_range = (bank < pagp_pkg::BANKS_PER_CHIP);
    flat = chip * pagp_pkg::BANKS_PER_CHIP + bank;
    fw = flat * 4 + idx / 8;
    fsh = (idx % 8) * 4;
    pw = flat * 2 + idx / 16;
    psh = (idx % 16) * 2;
    case (r.req_type)
      pagp_pkg::REQ_SETUP: begin
        o.bad_direction = (r.direction != pagp_pkg::DIR_INPUT) &&
                          (r.direction != pagp_pkg::DIR_OUTPUT);
        if (in_range) begin
          pull_words[pw][psh +: 2] = r.pull;
          if (r.direction == pagp_pkg::DIR_INPUT) func_words[fw][fsh +: 3] = 3'd0;
          else if (r.direction == pagp_pkg::DIR_OUTPUT) func_words[fw][fsh +: 3] = 3'd1;
        end
      end
      pagp_pkg::REQ_SET_PULL: begin
        if (in_range) pull_words[pw][psh +: 2] = r.pull;
      end
      pagp_pkg::REQ_WRITE_LVL: begin
        if (in_range) data_words[flat][idx] = r.level;
      end
      pagp_pkg::REQ_READ_LVL: begin
        if (in_range) o.read_value = {2'b00, data_words[flat][idx]};
      end
      pagp_pkg::REQ_READ_FUNC: begin
        if (in_range) o.read_value = func_words[fw][fsh +: 3];
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void queue_request(input logic [2:0] kind, input int unsigned pin,
                                        input logic [1:0] dir, input logic [1:0] pull,
                                        input logic level);
    pagp_pkg::req_t r;
    r.req_type = kind;
    r.pin = pin[pagp_pkg::PIN_W-1:0];
    r.direction = dir;
    r.pull = pull;
    r.level = level;
    queued_requests.push_back(r);
  endfunction

  // random pin, biased to small pools so reads meet earlier writes
  function automatic int unsigned pick_pin();
    case ($urandom_range(0, 3))
      0: return $urandom_range(FIRST_PIN, LAST_PIN);
      1: return $urandom_range(0, 15);
      2: return $urandom_range(MAX_PIN - 15, MAX_PIN);
      default: return $urandom_range(0, MAX_PIN);
    endcase
  endfunction

  function automatic void queue_random_request();
    logic [2:0] kind;
    logic [1:0] dir;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 20) kind = pagp_pkg::REQ_SETUP;
    else if (r < 32) kind = pagp_pkg::REQ_SET_PULL;
    else if (r < 52) kind = pagp_pkg::REQ_WRITE_LVL;
    else if (r < 72) kind = pagp_pkg::REQ_READ_LVL;
    else if (r < 94) kind = pagp_pkg::REQ_READ_FUNC;
    else kind = 3'($urandom_range(REQ_FIRST_UNKNOWN, REQ_LAST_UNKNOWN));
    if ($urandom_range(0, 9) < 8) begin
      dir = 2'($urandom_range(pagp_pkg::DIR_INPUT, pagp_pkg::DIR_OUTPUT));
    end else begin
      dir = 2'($urandom_range(DIR_FIRST_BAD, DIR_LAST_BAD));
    end
    queue_request(kind, pick_pin(), dir, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_valid || req_ready) begin
      if (send_gap != 0) begin
        req_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (queued_requests.size() != 0) begin
        req <= queued_requests.pop_front();
        req_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_stall <= 0;
    end else if (!hold_done && accepted_reqs >= HOLD_OFF_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_OFF_LEN;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      rsp_ready <= 1'b0;
    end else begin
      recv_stall <= pick_gap();
      rsp_ready <= 1'b1;
    end
  end

  // monitor: predict on request transfer, check on response transfer
  always @(posedge clk) begin
    pagp_pkg::rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predicted_rsps.push_back(apply_request(req));
        accepted_reqs <= accepted_reqs + 1;
      end
      if (rsp_valid && rsp_ready) begin
        if (predicted_rsps.size() == 0) begin
          $error("response transfer with nothing outstanding: read_value %0d bad_direction %0d",
                 rsp.read_value, rsp.bad_direction);
          error_count++;
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            error_count++;
          end
          if (rsp.bad_direction !== want.bad_direction) begin
            $error("bad_direction: expected %0d, got %0d", want.bad_direction,
                   rsp.bad_direction);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** pin_addressed_gpio_port: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (func_words[i]) func_words[i] = '0;
    foreach (pull_words[i]) pull_words[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;

    // directed: both chips, edge pins, every request, bad directions, unknown codes
    queue_request(pagp_pkg::REQ_SETUP, 0, pagp_pkg::DIR_OUTPUT, 2'd3, 1'b1);
    queue_request(pagp_pkg::REQ_READ_FUNC, 0, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SETUP, MAX_PIN, pagp_pkg::DIR_OUTPUT, 2'd2, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, MAX_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SETUP, FIRST_PIN, pagp_pkg::DIR_OUTPUT, 2'd1, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, FIRST_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, 0, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SETUP, LAST_PIN, DIR_FIRST_BAD, 2'd1, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, LAST_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SETUP, 0, DIR_LAST_BAD, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, 0, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_WRITE_LVL, LAST_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b1);
    queue_request(pagp_pkg::REQ_READ_LVL, LAST_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_READ_LVL, pagp_pkg::SECOND_CHIP_PINS - 1,
                  pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_WRITE_LVL, MAX_PIN, DIR_LAST_BAD, 2'd3, 1'b1);
    queue_request(pagp_pkg::REQ_READ_LVL, MAX_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_WRITE_LVL, MAX_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_READ_LVL, MAX_PIN, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SET_PULL, 100, DIR_LAST_BAD, 2'd3, 1'b1);
    queue_request(pagp_pkg::REQ_SETUP, 0, pagp_pkg::DIR_INPUT, 2'd0, 1'b1);
    queue_request(pagp_pkg::REQ_READ_FUNC, 0, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(pagp_pkg::REQ_SETUP, LAST_PIN + 1, pagp_pkg::DIR_OUTPUT, 2'd2, 1'b0);
    queue_request(pagp_pkg::REQ_READ_FUNC, LAST_PIN + 1, pagp_pkg::DIR_INPUT, 2'd0, 1'b0);
    queue_request(REQ_FIRST_UNKNOWN, MAX_PIN, DIR_LAST_BAD, 2'd3, 1'b1);
    queue_request(REQ_LAST_UNKNOWN, 0, DIR_LAST_BAD, 2'd3, 1'b1);

    // random part
    repeat (RANDOM_ITEMS) queue_random_request();

    // reset
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for the last request to transfer and every response to arrive
    do @(negedge clk); while (queued_requests.size() != 0 || req_valid);
    while (predicted_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("** pin_addressed_gpio_port: PASSED **");
    end else begin
      $display("** pin_addressed_gpio_port: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pagp_pkg.sv
design/pagp_ram.sv
design/pin_addressed_gpio_port.sv
bench/pin_addressed_gpio_port_test.sv
